[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FSLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FSLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FSLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define FSLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/fslc_pkg.sv]
// ----------------------------------------------------------------------------
// fslc_pkg
// Types, codes and constants of the FM seek and lock controller.
// ----------------------------------------------------------------------------
package fslc_pkg;

	localparam int FREQ_W = 11;
	localparam int DEV_W  = 12;

	typedef logic [FREQ_W-1:0] freq_t;
	typedef logic [DEV_W-1:0]  dev_t;

	localparam logic [1:0] OP_STEP = 2'd0;
	localparam logic [1:0] OP_SEEK = 2'd1;
	localparam logic [1:0] OP_MEAS = 2'd2;

	localparam logic [2:0] ST_IGNORED = 3'd0;
	localparam logic [2:0] ST_STEPPED = 3'd1;
	localparam logic [2:0] ST_TUNE    = 3'd2;
	localparam logic [2:0] ST_FOUND   = 3'd3;
	localparam logic [2:0] ST_NONE    = 3'd4;

	localparam logic CFG_LOW_LIMIT  = 1'b0;
	localparam logic CFG_HIGH_LIMIT = 1'b1;

	localparam freq_t LOW_LIMIT_RESET  = 11'd875;
	localparam freq_t HIGH_LIMIT_RESET = 11'd1080;

	localparam logic [5:0] SNR_FLOOR  = 6'd2;
	localparam logic [7:0] RSSI_FLOOR = 8'd10;
	localparam dev_t       DEV_WIN_LO = 12'd280;
	localparam dev_t       DEV_WIN_HI = 12'd3815;
	localparam dev_t       PREV_POS_MIN = 12'd20;
	localparam dev_t       PREV_NEG_MAX = 12'd4075;
	localparam int         DEV_SIGN_BIT = 11;

	typedef struct packed {
		logic [1:0] operation;
		logic       direction_down;
		logic [5:0] snr;
		logic [7:0] rssi;
		logic       afc_railed;
		dev_t       deviation;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		freq_t      tune_frequency;
		freq_t      playing_frequency;
		logic       muted;
	} result_t;

	typedef struct packed {
		freq_t playing_freq;
		freq_t seek_freq;
		freq_t seek_start_freq;
		logic  seek_dir_down;
		logic  seeking;
		freq_t last_checked_freq;
		dev_t  last_deviation;
	} state_t;

	function automatic freq_t step_wrap(input freq_t f, input logic down,
		input freq_t lo, input freq_t hi);
		logic signed [FREQ_W+1:0] n;
		logic signed [FREQ_W+1:0] lo_s;
		logic signed [FREQ_W+1:0] hi_s;
		lo_s = $signed({2'b00, lo});
		hi_s = $signed({2'b00, hi});
		n = $signed({2'b00, f}) + (down ? -13'sd1 : 13'sd1);
		if (n < lo_s) n = hi_s;
		if (n > hi_s) n = lo_s;
		return n[FREQ_W-1:0];
	endfunction

endpackage

[rtl/fslc_lock.sv]
// ----------------------------------------------------------------------------
// fslc_lock
// Lock test on one measurement at the current seek frequency.
// ----------------------------------------------------------------------------
module fslc_lock import fslc_pkg::*; (
	input  freq_t      freq,
	input  logic [5:0] snr,
	input  logic [7:0] rssi,
	input  logic       afc_railed,
	input  dev_t       deviation,
	input  freq_t      last_freq,
	input  dev_t       last_dev,
	input  freq_t      low_limit,
	output logic       locked
);

	logic fail_snr;
	logic fail_sig;
	logic fail_dev;
	logic fail_up;
	logic fail_dn;

	always_comb begin
		fail_snr = snr <= SNR_FLOOR;
		fail_sig = afc_railed || (rssi < RSSI_FLOOR);
		fail_dev = (deviation >= DEV_WIN_LO) && (deviation <= DEV_WIN_HI);
		fail_up  = (freq > low_limit)
			&& (({1'b0, last_freq} + 12'd1) == {1'b0, freq})
			&& (last_dev[DEV_SIGN_BIT] || (last_dev < PREV_POS_MIN));
		fail_dn  = (freq >= low_limit)
			&& (({1'b0, freq} + 12'd1) == {1'b0, last_freq})
			&& (!last_dev[DEV_SIGN_BIT] || (last_dev > PREV_NEG_MAX));
		locked = !(fail_snr || fail_sig || fail_dev || fail_up || fail_dn);
	end

endmodule

[rtl/fslc_ctrl.sv]
// ----------------------------------------------------------------------------
// fslc_ctrl
// Next state and result for one item: manual step, seek start, measurement.
// ----------------------------------------------------------------------------
module fslc_ctrl import fslc_pkg::*; (
	input  item_t   item,
	input  state_t  state,
	input  freq_t   low_limit,
	input  freq_t   high_limit,
	output state_t  state_next,
	output result_t result
);

	logic  locked;
	freq_t play_step;
	freq_t seek_step;

	fslc_lock u_lock (
		.freq       (state.seek_freq),
		.snr        (item.snr),
		.rssi       (item.rssi),
		.afc_railed (item.afc_railed),
		.deviation  (item.deviation),
		.last_freq  (state.last_checked_freq),
		.last_dev   (state.last_deviation),
		.low_limit  (low_limit),
		.locked     (locked)
	);

	always_comb begin
		play_step = step_wrap(state.playing_freq, item.direction_down,
			low_limit, high_limit);
		seek_step = step_wrap(state.seek_freq, state.seek_dir_down,
			low_limit, high_limit);
		state_next = state;
		result.status = ST_IGNORED;
		result.tune_frequency = state.seeking ? state.seek_freq : state.playing_freq;
		case (item.operation)
			OP_STEP: begin
				if (!state.seeking) begin
					state_next.playing_freq = play_step;
					result.status = ST_STEPPED;
					result.tune_frequency = play_step;
				end
			end
			OP_SEEK: begin
				if (!state.seeking) begin
					state_next.seeking = 1'b1;
					state_next.seek_dir_down = item.direction_down;
					state_next.seek_start_freq = state.playing_freq;
					state_next.seek_freq = play_step;
					result.status = ST_TUNE;
					result.tune_frequency = play_step;
				end
			end
			OP_MEAS: begin
				if (state.seeking) begin
					state_next.last_checked_freq = state.seek_freq;
					state_next.last_deviation = item.deviation;
					if (locked) begin
						state_next.playing_freq = state.seek_freq;
						state_next.seeking = 1'b0;
						result.status = ST_FOUND;
						result.tune_frequency = state.seek_freq;
					end else if (state.seek_freq == state.seek_start_freq) begin
						state_next.seeking = 1'b0;
						result.status = ST_NONE;
						result.tune_frequency = state.playing_freq;
					end else begin
						state_next.seek_freq = seek_step;
						result.status = ST_TUNE;
						result.tune_frequency = seek_step;
					end
				end
			end
			default: begin
			end
		endcase
		result.playing_frequency = state_next.playing_freq;
		result.muted = state_next.seeking;
	end

endmodule

[rtl/fm_seek_lock_controller.sv]
// ----------------------------------------------------------------------------
// fm_seek_lock_controller
// Tuner seek and step controller with lock test on tuner measurements.
// ----------------------------------------------------------------------------
//  channel   | signals                              | role
//  item      | item_valid, item_ready, item         | step, seek start, measurement
//  result    | result_valid, result_ready, result   | status and frequencies
//  config    | cfg_we, cfg_index, cfg_data          | band low and high limits
//
//  One item per cycle while the result is not stalled; an accepted item passes
//  through the input register, then one evaluation step into the result register.
//  The evaluation step reads and writes the seek state in the same cycle.
//  Reset clears the seek state, sets the playing frequency to the low limit
//  reset value and loads both limits with their reset values.
//  A stalled result holds the input register; one item waits there.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fm_seek_lock_controller import fslc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result,
	input  logic    cfg_we,
	input  logic    cfg_index,
	input  freq_t   cfg_data
);

	item_t   item_s1;
	logic    item_valid_s1;
	result_t result_s2;
	logic    result_valid_s2;
	state_t  state_q;
	state_t  state_next;
	result_t result_next;
	freq_t   low_limit_q;
	freq_t   high_limit_q;
	logic    fire;

	assign fire = item_valid_s1 && (!result_valid_s2 || result_ready);
	assign item_ready = !item_valid_s1 || fire;
	assign result_valid = result_valid_s2;
	assign result = result_s2;

	fslc_ctrl u_ctrl (
		.item       (item_s1),
		.state      (state_q),
		.low_limit  (low_limit_q),
		.high_limit (high_limit_q),
		.state_next (state_next),
		.result     (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q <= LOW_LIMIT_RESET;
			high_limit_q <= HIGH_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOW_LIMIT: low_limit_q <= cfg_data;
				CFG_HIGH_LIMIT: high_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (fire) begin
			result_valid_s2 <= 1'b1;
		end else if (result_ready) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) result_s2 <= result_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{playing_freq: LOW_LIMIT_RESET, default: '0};
		end else if (fire) begin
			state_q <= state_next;
		end
	end

	`FSLC_ASSERT_NEXT(a_hold_s1, clk, arst_n, item_valid_s1 && !fire, item_valid_s1)
	`FSLC_ASSERT_NEXT(a_ignored_keeps_state, clk, arst_n, fire && (result_next.status == ST_IGNORED), $stable(state_q))
	`FSLC_ASSERT_SAME(a_tune_muted, clk, arst_n, result_valid_s2 && (result_s2.status == ST_TUNE), result_s2.muted)
	`FSLC_ASSERT_SAME(a_done_unmuted, clk, arst_n, result_valid_s2 && (result_s2.status == ST_FOUND || result_s2.status == ST_NONE || result_s2.status == ST_STEPPED), !result_s2.muted)

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FM seek and lock controller. A clocked driver
// sends step, seek and measurement items in random bursts; a clocked monitor
// compares every result, field by field, with a cycle-free model of the
// tuner state kept in this file. The band limits change between phases,
// including crossed, single-channel and full-range settings.
// ----------------------------------------------------------------------------
module testbench;
	import fslc_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int PHASES = 12;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	logic    cfg_we;
	logic    cfg_index;
	freq_t   cfg_data;

	fm_seek_lock_controller uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	freq_t       band_lo     = LOW_LIMIT_RESET;
	freq_t       band_hi     = HIGH_LIMIT_RESET;
	freq_t       play_f      = LOW_LIMIT_RESET;
	freq_t       seek_f      = '0;
	freq_t       seek_origin = '0;
	logic        seek_down   = 1'b0;
	logic        seeking     = 1'b0;
	logic [15:0] chk_freq    = '0;
	dev_t        chk_dev     = '0;

	item_t   item_queue[$];
	result_t expected_results[$];
	result_t want;
	int      fail_count = 0;
	int      items_sent = 0;
	int      results_checked = 0;
	int      status_seen[5] = '{0, 0, 0, 0, 0};
	int      band_settings = 1;
	int      burst_left;
	int      gap_left;
	int      stall_mode;
	int      mode_left;
	logic [31:0] stall_pat;

	function automatic freq_t next_channel(input freq_t f, input logic down);
		int n;
		n = int'(f) + (down ? -1 : 1);
		if (n < int'(band_lo)) n = int'(band_hi);
		if (n > int'(band_hi)) n = int'(band_lo);
		return freq_t'(n);
	endfunction

	function automatic logic station_locks(input freq_t f, input item_t it);
		int   base;
		dev_t prev;
		logic ok;
		base = int'(chk_freq);
		prev = chk_dev;
		ok = 1'b1;
		if (it.snr <= SNR_FLOOR)
			ok = 1'b0;
		else if (it.afc_railed || it.rssi < RSSI_FLOOR)
			ok = 1'b0;
		else if (it.deviation >= DEV_WIN_LO && it.deviation <= DEV_WIN_HI)
			ok = 1'b0;
		else if (f > band_lo && base + 1 == int'(f) &&
				(prev[DEV_SIGN_BIT] || prev < PREV_POS_MIN))
			ok = 1'b0;
		else if (f >= band_lo && int'(f) + 1 == base &&
				(!prev[DEV_SIGN_BIT] || prev > PREV_NEG_MAX))
			ok = 1'b0;
		chk_dev = it.deviation;
		chk_freq = {5'b0, f};
		return ok;
	endfunction

	function automatic result_t tuner_next(input item_t it);
		result_t r;
		r.status = ST_IGNORED;
		r.tune_frequency = seeking ? seek_f : play_f;
		if (it.operation == OP_STEP && !seeking) begin
			play_f = next_channel(play_f, it.direction_down);
			r.status = ST_STEPPED;
			r.tune_frequency = play_f;
		end else if (it.operation == OP_SEEK && !seeking) begin
			seeking = 1'b1;
			seek_down = it.direction_down;
			seek_origin = play_f;
			seek_f = next_channel(play_f, it.direction_down);
			r.status = ST_TUNE;
			r.tune_frequency = seek_f;
		end else if (it.operation == OP_MEAS && seeking) begin
			if (station_locks(seek_f, it)) begin
				play_f = seek_f;
				seeking = 1'b0;
				r.status = ST_FOUND;
				r.tune_frequency = seek_f;
			end else if (seek_f == seek_origin) begin
				seeking = 1'b0;
				r.status = ST_NONE;
				r.tune_frequency = play_f;
			end else begin
				seek_f = next_channel(seek_f, seek_down);
				r.status = ST_TUNE;
				r.tune_frequency = seek_f;
			end
		end
		r.playing_frequency = play_f;
		r.muted = seeking;
		return r;
	endfunction

	function automatic item_t mk(input logic [1:0] op, input logic down,
		input logic [5:0] snr, input logic [7:0] rssi, input logic afc,
		input dev_t dev);
		return item_t'{op, down, snr, rssi, afc, dev};
	endfunction

	function automatic item_t any_item();
		return item_t'($urandom);
	endfunction

	function automatic item_t rand_meas();
		item_t it;
		it = any_item();
		it.operation = OP_MEAS;
		if ($urandom_range(0, 9) < 4) begin
			it.snr = 6'($urandom_range(3, 63));
			it.rssi = 8'($urandom_range(10, 255));
			it.afc_railed = 1'b0;
			it.deviation = $urandom_range(0, 1) ? dev_t'($urandom_range(0, 279))
				: dev_t'($urandom_range(3816, 4095));
		end
		return it;
	endfunction

	// Driver: bursts of items with random gaps; valid holds until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (item_valid && item_ready) begin
				expected_results.push_back(tuner_next(item));
				items_sent++;
			end
			if (!item_valid || item_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (item_queue.size() > 0) begin
					item <= item_queue.pop_front();
					item_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall on a pattern that changes mode every so often.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_mode = 0;
			mode_left = 0;
			stall_pat = 32'h1;
		end else begin
			if (mode_left <= 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
				stall_pat = $urandom | 32'h1;
			end
			mode_left--;
			case (stall_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= ($urandom_range(0, 3) != 0);
				2: begin
					result_ready <= stall_pat[0];
					stall_pat = {stall_pat[0], stall_pat[31:1]};
				end
				default: result_ready <= $urandom_range(0, 1);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d tune %0d", result.status,
					result.tune_frequency);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (want.status < 5) status_seen[want.status]++;
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					fail_count++;
				end
				if (result.tune_frequency !== want.tune_frequency) begin
					$error("tune_frequency: expected %0d, got %0d", want.tune_frequency,
						result.tune_frequency);
					fail_count++;
				end
				if (result.playing_frequency !== want.playing_frequency) begin
					$error("playing_frequency: expected %0d, got %0d",
						want.playing_frequency, result.playing_frequency);
					fail_count++;
				end
				if (result.muted !== want.muted) begin
					$error("muted: expected %0d, got %0d", want.muted, result.muted);
					fail_count++;
				end
			end
		end
	end

	task automatic drain();
		while (item_queue.size() != 0 || item_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_band(input freq_t lo, input freq_t hi);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_LOW_LIMIT;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= CFG_HIGH_LIMIT;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		band_lo = lo;
		band_hi = hi;
		band_settings++;
		@(negedge clk);
	endtask

	task automatic queue_random(input int count);
		int   n;
		int   kind;
		item_t it;
		n = 0;
		while (n < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				it = any_item();
				it.operation = OP_SEEK;
				item_queue.push_back(it);
				n++;
				repeat ($urandom_range(1, 14)) begin
					item_queue.push_back(rand_meas());
					n++;
				end
			end else if (kind < 8) begin
				repeat ($urandom_range(1, 6)) begin
					it = any_item();
					it.operation = OP_STEP;
					item_queue.push_back(it);
					n++;
				end
			end else begin
				item_queue.push_back(any_item());
				n++;
			end
		end
	endtask

	initial begin
		freq_t lo_tab[8];
		freq_t hi_tab[8];
		freq_t lo;
		freq_t hi;
		int    ph;
		lo_tab = '{11'd0, 11'd0, 11'd2047, 11'd2040, 11'd0, 11'd1500, 11'd1000, 11'd875};
		hi_tab = '{11'd2047, 11'd0, 11'd2047, 11'd2047, 11'd5, 11'd1400, 11'd1003, 11'd1080};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LOW_LIMIT;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// wrap at both limits, ignored cases, each lock test but the downward neighbour test failing in turn
		item_queue.push_back(mk(OP_STEP, 1'b1, 6'd0, 8'd0, 1'b0, 12'd0));
		item_queue.push_back(mk(OP_STEP, 1'b0, 6'd0, 8'd0, 1'b0, 12'd0));
		item_queue.push_back(mk(OP_NONE, 1'b1, 6'd63, 8'd255, 1'b1, 12'd4095));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd40, 8'd120, 1'b0, 12'd0));
		item_queue.push_back(mk(OP_SEEK, 1'b0, 6'd0, 8'd0, 1'b0, 12'd0));
		item_queue.push_back(mk(OP_STEP, 1'b1, 6'd0, 8'd0, 1'b0, 12'd0));
		item_queue.push_back(mk(OP_SEEK, 1'b1, 6'd0, 8'd0, 1'b0, 12'd0));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd2, 8'd255, 1'b0, 12'd0));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd63, 8'd255, 1'b1, 12'd0));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd63, 8'd9, 1'b0, 12'd100));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd3, 8'd10, 1'b0, 12'd280));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd3, 8'd10, 1'b0, 12'd3815));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd3, 8'd10, 1'b0, 12'd4095));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd0, 8'd10, 1'b0, 12'd100));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd3, 8'd10, 1'b0, 12'd279));
		item_queue.push_back(mk(OP_SEEK, 1'b1, 6'd0, 8'd0, 1'b0, 12'd0));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd0, 8'd200, 1'b0, 12'd4000));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd30, 8'd200, 1'b0, 12'd3816));
		drain();

		// seek from off band until lock, then a full circle with no station
		write_band(11'd100, 11'd103);
		item_queue.push_back(mk(OP_SEEK, 1'b0, 6'd0, 8'd0, 1'b0, 12'd0));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd0, 8'd50, 1'b0, 12'd50));
		item_queue.push_back(mk(OP_MEAS, 1'b0, 6'd20, 8'd50, 1'b0, 12'd10));
		item_queue.push_back(mk(OP_SEEK, 1'b1, 6'd0, 8'd0, 1'b0, 12'd0));
		repeat (4) item_queue.push_back(mk(OP_MEAS, 1'b1, 6'd1, 8'd90, 1'b0, 12'd0));
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph < 8) begin
				lo = lo_tab[ph];
				hi = hi_tab[ph];
			end else begin
				lo = freq_t'($urandom_range(0, 2047));
				if ($urandom_range(0, 3) == 0)
					hi = freq_t'($urandom_range(0, 2047));
				else
					hi = (int'(lo) + 10 > 2047) ? 11'd2047
						: freq_t'(int'(lo) + int'($urandom_range(0, 10)));
			end
			write_band(lo, hi);
			queue_random(128);
			drain();
		end

		repeat (20) @(posedge clk);
		$display("%0d items, %0d results checked across %0d band settings",
			items_sent, results_checked, band_settings);
		$display("stepped %0d, tune next %0d, found %0d, none found %0d, ignored %0d",
			status_seen[ST_STEPPED], status_seen[ST_TUNE], status_seen[ST_FOUND],
			status_seen[ST_NONE], status_seen[ST_IGNORED]);
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#5000000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
